FILE: hdl/jlpp_pkg.sv
// ----------------------------------------------------------------------------
// jlpp_pkg
// Shared types and constants of the jerk-limited profile planner.
// ----------------------------------------------------------------------------
package jlpp_pkg;

  // configuration port geometry
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // register indexes
  typedef enum logic [0:0] {
    REG_JERK_LIMIT  = 1'b0,
    REG_ACCEL_LIMIT = 1'b1
  } reg_idx_e;

  localparam logic [31:0] RST_JERK_LIMIT  = 32'd655360;
  localparam logic [31:0] RST_ACCEL_LIMIT = 32'd65536;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // saturation bound of intermediate values
  localparam logic [63:0] INNER_LIM = 64'h3FFF_FFFF_FFFF_FFFF;
  // upper clamp of the curve time taken from the square root search
  localparam logic [63:0] TP_MAX    = 64'h0000_07FF_FFFF_FFFF;
  localparam logic [31:0] DIV_SIX   = 32'd6;

  // width of the dividend register of the shared divide / root unit
  function automatic int unsigned num_width(int unsigned frac);
    return ((32 + 2 * frac) > 64) ? (32 + 2 * frac) : 64;
  endfunction

  typedef struct packed {
    logic signed [31:0] start_velocity;
    logic signed [31:0] end_velocity;
  } item_t;

  typedef struct packed {
    logic        [31:0] time_first_curve_end;
    logic        [31:0] time_linear_end;
    logic        [31:0] time_total;
    logic signed [31:0] velocity_after_first;
    logic signed [31:0] velocity_before_last;
    logic signed [47:0] distance_after_first;
    logic signed [47:0] distance_before_last;
    logic signed [47:0] distance_total;
    logic               has_linear_phase;
    logic               decelerating;
    logic               saturated;
  } result_t;

  // classified item as handed from front to back
  typedef struct packed {
    logic signed [31:0] v0;
    logic signed [31:0] v3;
    logic        [31:0] dv;
    logic        [31:0] jerk;
    logic        [31:0] accel;
    logic               dec;
    logic               lin;
  } entry_t;

  typedef enum logic [1:0] {
    ALU_MUL  = 2'd0,
    ALU_DIV  = 2'd1,
    ALU_SQRT = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_cmd_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } alu_stat_t;

endpackage

FILE: hdl/jlpp_stream_if.sv
// ----------------------------------------------------------------------------
// jlpp_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface jlpp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/jlpp_front.sv
// ----------------------------------------------------------------------------
// jlpp_front
// Accepts velocity pairs, finds direction and magnitude of the change and
// decides whether a constant-acceleration segment exists.
// ----------------------------------------------------------------------------
module jlpp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         jerk_limit_i,
  input  logic [31:0]         accel_limit_i,
  jlpp_stream_if.sink         item_i,
  jlpp_stream_if.source       entry_o
);

  logic               s_valid_q;
  logic signed [31:0] v0_q, v3_q;
  logic        [31:0] dv_q, jerk_q, accel_q;
  logic               dec_q;

  logic               acc_in;
  logic               dec_d;
  logic signed [32:0] diff_d;
  logic        [63:0] prod_dj, prod_aa;

  assign item_i.ready = !s_valid_q || entry_o.ready;
  assign acc_in       = item_i.valid && item_i.ready;

  // direction and magnitude of the velocity change
  always_comb begin
    dec_d = !(item_i.data.end_velocity > item_i.data.start_velocity);
    if (dec_d) begin
      diff_d = 33'(item_i.data.start_velocity) - 33'(item_i.data.end_velocity);
    end else begin
      diff_d = 33'(item_i.data.end_velocity) - 33'(item_i.data.start_velocity);
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (acc_in) begin
      s_valid_q <= 1'b1;
    end else if (entry_o.ready) begin
      s_valid_q <= 1'b0;
    end
  end

  // stage payload, zero limits act as one
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      v0_q    <= item_i.data.start_velocity;
      v3_q    <= item_i.data.end_velocity;
      dv_q    <= diff_d[31:0];
      dec_q   <= dec_d;
      jerk_q  <= (jerk_limit_i == 32'd0) ? 32'd1 : jerk_limit_i;
      accel_q <= (accel_limit_i == 32'd0) ? 32'd1 : accel_limit_i;
    end
  end

  // line exists when dv * jerk exceeds accel squared
  assign prod_dj = dv_q * jerk_q;
  assign prod_aa = accel_q * accel_q;

  assign entry_o.valid      = s_valid_q;
  assign entry_o.data.v0    = v0_q;
  assign entry_o.data.v3    = v3_q;
  assign entry_o.data.dv    = dv_q;
  assign entry_o.data.jerk  = jerk_q;
  assign entry_o.data.accel = accel_q;
  assign entry_o.data.dec   = dec_q;
  assign entry_o.data.lin   = prod_dj > prod_aa;

endmodule

FILE: hdl/jlpp_queue.sv
// ----------------------------------------------------------------------------
// jlpp_queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module jlpp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  jlpp_stream_if.sink   push_i,
  jlpp_stream_if.source pop_o
);

  localparam int unsigned PTR_W = $clog2(jlpp_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(jlpp_pkg::QUEUE_DEPTH + 1);

  jlpp_pkg::entry_t   slot_q [jlpp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign push_i.ready = (cnt_q != CNT_W'(jlpp_pkg::QUEUE_DEPTH));
  assign pop_o.valid  = (cnt_q != '0);
  assign pop_o.data   = slot_q[rd_ptr_q];
  assign do_push      = push_i.valid && push_i.ready;
  assign do_pop       = pop_o.valid && pop_o.ready;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(jlpp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(jlpp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_i.data;
    end
  end

endmodule

FILE: hdl/jlpp_alu.sv
// ----------------------------------------------------------------------------
// jlpp_alu
// Shared multi-cycle unit: fixed-point multiply with saturation, radix-4
// restoring divide and bit-pair integer square root.
// ----------------------------------------------------------------------------
module jlpp_alu #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  jlpp_pkg::alu_cmd_t                                    cmd_i,
  input  logic [jlpp_pkg::num_width(FRACTION_BITS)-1:0]         op_a_i,
  input  logic [63:0]                                           op_b_i,
  output logic [jlpp_pkg::num_width(FRACTION_BITS)-1:0]         res_o,
  output jlpp_pkg::alu_stat_t                                   stat_o
);

  localparam int unsigned NUM_W  = jlpp_pkg::num_width(FRACTION_BITS);
  localparam int unsigned HALF_W = NUM_W / 2;
  localparam int unsigned CNT_W  = $clog2(HALF_W);
  localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(HALF_W - 1);

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_MUL  = 5'b00010,
    A_MFIN = 5'b00100,
    A_ITER = 5'b01000,
    A_DONE = 5'b10000
  } alu_state_e;

  alu_state_e          state_q;
  jlpp_pkg::alu_op_e   op_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [NUM_W-1:0]    num_q;
  logic [31:0]         rem_q;
  logic [HALF_W-1:0]   root_q;
  logic [HALF_W+1:0]   srem_q;
  logic [63:0]         ma_q, mb_q, res_q;
  logic [127:0]        acc_q;
  logic                neg_q, ovf_q;

  logic [31:0]         pa, pb;
  logic [63:0]         prod;
  logic [127:0]        part;
  logic [127:0]        shifted;
  logic [63:0]         mag;
  logic                mag_ovf;
  logic [NUM_W-1:0]    dn;
  logic [31:0]         dr;
  logic [32:0]         dt;
  logic [NUM_W-1:0]    sn;
  logic [HALF_W+3:0]   sr, trial, sdiff;
  logic [HALF_W+1:0]   srem_n;
  logic [HALF_W-1:0]   root_n;

  // one 32x32 partial product per cycle
  always_comb begin
    pa   = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
    pb   = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
    prod = pa * pb;
    case (cnt_q[1:0])
      2'b00:   part = {64'd0, prod};
      2'b11:   part = {prod, 64'd0};
      default: part = {32'd0, prod, 32'd0};
    endcase
  end

  // drop fraction bits and clamp the magnitude
  always_comb begin
    shifted = acc_q >> FRACTION_BITS;
    mag_ovf = (shifted[127:64] != 64'd0) || (shifted[63:0] > jlpp_pkg::INNER_LIM);
    mag     = mag_ovf ? jlpp_pkg::INNER_LIM : shifted[63:0];
  end

  // two quotient bits per cycle
  always_comb begin
    dn = num_q;
    dr = rem_q;
    dt = '0;
    for (int k = 0; k < 2; k++) begin
      dt = {dr, dn[NUM_W-1]};
      dn = {dn[NUM_W-2:0], 1'b0};
      if (dt >= {1'b0, mb_q[31:0]}) begin
        dt    = dt - {1'b0, mb_q[31:0]};
        dn[0] = 1'b1;
      end
      dr = dt[31:0];
    end
  end

  // one root bit per cycle
  always_comb begin
    sr    = {srem_q, num_q[NUM_W-1 -: 2]};
    trial = (HALF_W+4)'({root_q, 2'b01});
    sdiff = sr - trial;
    sn    = {num_q[NUM_W-3:0], 2'b00};
    if (sr >= trial) begin
      srem_n = sdiff[HALF_W+1:0];
      root_n = {root_q[HALF_W-2:0], 1'b1};
    end else begin
      srem_n = sr[HALF_W+1:0];
      root_n = {root_q[HALF_W-2:0], 1'b0};
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        A_IDLE: begin
          if (cmd_i.start) begin
            case (cmd_i.op)
              jlpp_pkg::ALU_MUL: begin
                state_q <= A_MUL;
                cnt_q   <= '0;
              end
              default: begin
                state_q <= A_ITER;
                cnt_q   <= ITER_LAST;
              end
            endcase
          end
        end
        A_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q[1:0] == 2'b11) begin
            state_q <= A_MFIN;
          end
        end
        A_MFIN: state_q <= A_DONE;
        A_ITER: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= A_DONE;
          end
        end
        A_DONE:  state_q <= A_IDLE;
        default: state_q <= A_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      A_IDLE: begin
        if (cmd_i.start) begin
          op_q   <= cmd_i.op;
          ovf_q  <= 1'b0;
          num_q  <= op_a_i;
          rem_q  <= '0;
          srem_q <= '0;
          root_q <= '0;
          acc_q  <= '0;
          neg_q  <= op_a_i[63] ^ op_b_i[63];
          if (cmd_i.op == jlpp_pkg::ALU_MUL) begin
            ma_q <= op_a_i[63] ? (64'd0 - op_a_i[63:0]) : op_a_i[63:0];
            mb_q <= op_b_i[63] ? (64'd0 - op_b_i) : op_b_i;
          end else begin
            ma_q <= op_a_i[63:0];
            mb_q <= op_b_i;
          end
        end
      end
      A_MUL:  acc_q <= acc_q + part;
      A_MFIN: begin
        res_q <= neg_q ? (64'd0 - mag) : mag;
        ovf_q <= mag_ovf;
      end
      A_ITER: begin
        if (op_q == jlpp_pkg::ALU_DIV) begin
          num_q <= dn;
          rem_q <= dr;
        end else begin
          num_q  <= sn;
          srem_q <= srem_n;
          root_q <= root_n;
        end
      end
      default: ;
    endcase
  end

  // result select
  always_comb begin
    case (op_q)
      jlpp_pkg::ALU_MUL: res_o = NUM_W'($signed(res_q));
      jlpp_pkg::ALU_DIV: res_o = num_q;
      default:           res_o = NUM_W'(root_q);
    endcase
  end

  assign stat_o.done = (state_q == A_DONE);
  assign stat_o.ovf  = ovf_q;

endmodule

FILE: hdl/jlpp_back.sv
// ----------------------------------------------------------------------------
// jlpp_back
// Plans one profile at a time on the shared arithmetic unit and holds the
// finished result in an output register.
// ----------------------------------------------------------------------------
module jlpp_back #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  jlpp_stream_if.sink   entry_i,
  jlpp_stream_if.source result_o
);

  localparam int unsigned NUM_W = jlpp_pkg::num_width(FRACTION_BITS);
  localparam logic signed [63:0] LIM_S   = $signed(jlpp_pkg::INNER_LIM);
  localparam logic signed [63:0] V_MAX   = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] V_MIN   = -V_MAX - 64'sd1;
  localparam logic signed [63:0] D_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] D_MIN   = -D_MAX - 64'sd1;

  typedef enum logic [18:0] {
    ST_IDLE = 19'b000_0000_0000_0000_0001,
    ST_TC   = 19'b000_0000_0000_0000_0010,
    ST_TQ   = 19'b000_0000_0000_0000_0100,
    ST_LP1  = 19'b000_0000_0000_0000_1000,
    ST_LP2  = 19'b000_0000_0000_0001_0000,
    ST_LP3  = 19'b000_0000_0000_0010_0000,
    ST_LP4  = 19'b000_0000_0000_0100_0000,
    ST_LD6  = 19'b000_0000_0000_1000_0000,
    ST_LP5  = 19'b000_0000_0001_0000_0000,
    ST_LP6  = 19'b000_0000_0010_0000_0000,
    ST_CQ   = 19'b000_0000_0100_0000_0000,
    ST_CSQ  = 19'b000_0000_1000_0000_0000,
    ST_CM1  = 19'b000_0001_0000_0000_0000,
    ST_CM2  = 19'b000_0010_0000_0000_0000,
    ST_CM3  = 19'b000_0100_0000_0000_0000,
    ST_CD6  = 19'b000_1000_0000_0000_0000,
    ST_CM4  = 19'b001_0000_0000_0000_0000,
    ST_CM5  = 19'b010_0000_0000_0000_0000,
    ST_OUT  = 19'b100_0000_0000_0000_0000
  } step_e;

  // saturating add or subtract, returns {sat, value}
  function automatic logic [64:0] sat_add(logic signed [63:0] x, logic signed [63:0] y,
                                          logic sub);
    logic signed [64:0] s;
    s = sub ? (65'(x) - 65'(y)) : (65'(x) + 65'(y));
    if (s > 65'(LIM_S)) begin
      return {1'b1, LIM_S};
    end else if (s < -65'(LIM_S)) begin
      return {1'b1, -LIM_S};
    end
    return {1'b0, s[63:0]};
  endfunction

  // clamp to unsigned 32 bits, returns {sat, value}
  function automatic logic [32:0] clamp_u32(logic [63:0] x);
    if (x[63:32] != 32'd0) begin
      return {1'b1, 32'hFFFF_FFFF};
    end
    return {1'b0, x[31:0]};
  endfunction

  // clamp to signed 32 bits
  function automatic logic [32:0] clamp_s32(logic signed [63:0] x);
    if (x > V_MAX) begin
      return {1'b1, V_MAX[31:0]};
    end else if (x < V_MIN) begin
      return {1'b1, V_MIN[31:0]};
    end
    return {1'b0, x[31:0]};
  endfunction

  // clamp to signed 48 bits
  function automatic logic [48:0] clamp_s48(logic signed [63:0] x);
    if (x > D_MAX) begin
      return {1'b1, D_MAX[47:0]};
    end else if (x < D_MIN) begin
      return {1'b1, D_MIN[47:0]};
    end
    return {1'b0, x[47:0]};
  endfunction

  step_e               step_q;
  logic                wait_q;
  logic                out_valid_q;
  jlpp_pkg::result_t   out_q;

  logic signed [31:0]  v0_q, mid_q;
  logic        [31:0]  dv_q, jerk_q, accel_q;
  logic                dec_q, lin_q, sat_q;
  logic        [63:0]  tc_q, tm_q;
  logic signed [63:0]  p1_q, p4_q, v1_q, v2_q, x1_q, x2_q, x3_q;
  logic [NUM_W-1:0]    qq_q;

  jlpp_pkg::alu_cmd_t  cmd;
  jlpp_pkg::alu_stat_t stat;
  logic [NUM_W-1:0]    op_a;
  logic [63:0]         op_b;
  logic [NUM_W-1:0]    alu_res;
  logic [63:0]         res64;
  logic signed [63:0]  mres;
  logic [64:0]         sum_r;
  logic                take;
  logic                out_free;
  logic signed [32:0]  half_sum;
  logic signed [31:0]  mid_d;
  logic [63:0]         t2, t3;
  logic [32:0]         c_t1, c_t2, c_t3, c_v1, c_v2;
  logic [48:0]         c_x1, c_x2, c_x3;
  jlpp_pkg::result_t   res_d;

  jlpp_alu #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .res_o  (alu_res),
    .stat_o (stat)
  );

  assign res64    = alu_res[63:0];
  assign mres     = $signed(alu_res[63:0]);
  assign take     = wait_q && stat.done;
  assign out_free = !out_valid_q || result_o.ready;

  assign entry_i.ready = (step_q == ST_IDLE);

  // mid velocity, truncated toward zero
  always_comb begin
    half_sum = 33'(entry_i.data.v0) + 33'(entry_i.data.v3);
    half_sum = (half_sum + 33'(half_sum[32])) >>> 1;
    mid_d    = half_sum[31:0];
  end

  // operand select for the step being issued
  always_comb begin
    cmd.start = !wait_q && (step_q != ST_IDLE) && (step_q != ST_OUT);
    cmd.op    = jlpp_pkg::ALU_MUL;
    op_a      = '0;
    op_b      = '0;
    case (step_q)
      ST_TC: begin
        cmd.op = jlpp_pkg::ALU_DIV;
        op_a   = NUM_W'(accel_q) << FRACTION_BITS;
        op_b   = 64'(jerk_q);
      end
      ST_TQ: begin
        cmd.op = jlpp_pkg::ALU_DIV;
        op_a   = NUM_W'(dv_q) << FRACTION_BITS;
        op_b   = 64'(accel_q);
      end
      ST_LP1: begin
        op_a = NUM_W'(accel_q);
        op_b = tc_q;
      end
      ST_LP2: begin
        op_a = NUM_W'(accel_q);
        op_b = tm_q;
      end
      ST_LP3: begin
        op_a = NUM_W'($signed(v0_q));
        op_b = tc_q;
      end
      ST_LP4, ST_CM2, ST_CM3: begin
        op_a = NUM_W'(p1_q);
        op_b = tc_q;
      end
      ST_LD6, ST_CD6: begin
        cmd.op = jlpp_pkg::ALU_DIV;
        op_a   = NUM_W'(p4_q);
        op_b   = 64'(jlpp_pkg::DIV_SIX);
      end
      ST_LP5: begin
        op_a = NUM_W'(v1_q);
        op_b = tm_q;
      end
      ST_LP6: begin
        op_a = NUM_W'($signed(mid_q));
        op_b = (tc_q << 1) + tm_q;
      end
      ST_CQ: begin
        cmd.op = jlpp_pkg::ALU_DIV;
        op_a   = NUM_W'(dv_q) << (2 * FRACTION_BITS);
        op_b   = 64'(jerk_q);
      end
      ST_CSQ: begin
        cmd.op = jlpp_pkg::ALU_SQRT;
        op_a   = qq_q;
      end
      ST_CM1: begin
        op_a = NUM_W'(jerk_q);
        op_b = tc_q;
      end
      ST_CM4: begin
        op_a = NUM_W'($signed(mid_q));
        op_b = tc_q;
      end
      ST_CM5: begin
        op_a = NUM_W'($signed({mid_q, 1'b0}));
        op_b = tc_q;
      end
      default: ;
    endcase
  end

  // saturating add used when a step completes
  always_comb begin
    case (step_q)
      ST_LP1:  sum_r = sat_add(64'($signed(v0_q)), mres >>> 1, dec_q);
      ST_LP2:  sum_r = sat_add(v1_q, mres, dec_q);
      ST_LD6:  sum_r = sat_add(x1_q, $signed(res64), dec_q);
      ST_LP5:  sum_r = sat_add(x1_q, mres, 1'b0);
      ST_CM4:  sum_r = sat_add(mres, p4_q, dec_q);
      default: sum_r = '0;
    endcase
  end

  // step sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
      wait_q <= 1'b0;
    end else begin
      if (cmd.start) begin
        wait_q <= 1'b1;
      end else if (take) begin
        wait_q <= 1'b0;
      end
      case (step_q)
        ST_IDLE: begin
          if (entry_i.valid) begin
            step_q <= entry_i.data.lin ? ST_TC : ST_CQ;
          end
        end
        ST_TC:  if (take) step_q <= ST_TQ;
        ST_TQ:  if (take) step_q <= ST_LP1;
        ST_LP1: if (take) step_q <= ST_LP2;
        ST_LP2: if (take) step_q <= ST_LP3;
        ST_LP3: if (take) step_q <= ST_LP4;
        ST_LP4: if (take) step_q <= ST_LD6;
        ST_LD6: if (take) step_q <= ST_LP5;
        ST_LP5: if (take) step_q <= ST_LP6;
        ST_LP6: if (take) step_q <= ST_OUT;
        ST_CQ:  if (take) step_q <= ST_CSQ;
        ST_CSQ: if (take) step_q <= ST_CM1;
        ST_CM1: if (take) step_q <= ST_CM2;
        ST_CM2: if (take) step_q <= ST_CM3;
        ST_CM3: if (take) step_q <= ST_CD6;
        ST_CD6: if (take) step_q <= ST_CM4;
        ST_CM4: if (take) step_q <= ST_CM5;
        ST_CM5: if (take) step_q <= ST_OUT;
        ST_OUT: if (out_free) step_q <= ST_IDLE;
        default: step_q <= ST_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (step_q == ST_IDLE && entry_i.valid) begin
      v0_q    <= entry_i.data.v0;
      dv_q    <= entry_i.data.dv;
      jerk_q  <= entry_i.data.jerk;
      accel_q <= entry_i.data.accel;
      dec_q   <= entry_i.data.dec;
      lin_q   <= entry_i.data.lin;
      mid_q   <= mid_d;
      v1_q    <= 64'(mid_d);
      v2_q    <= 64'(mid_d);
      tm_q    <= '0;
      sat_q   <= 1'b0;
    end else if (take) begin
      if (cmd.op == jlpp_pkg::ALU_MUL) begin
        sat_q <= sat_q | stat.ovf | sum_r[64];
      end else begin
        sat_q <= sat_q | sum_r[64];
      end
      case (step_q)
        ST_TC:  tc_q <= res64;
        ST_TQ:  tm_q <= (res64 > tc_q) ? (res64 - tc_q) : 64'd0;
        ST_LP1: begin
          p1_q <= mres;
          v1_q <= sum_r[63:0];
        end
        ST_LP2: v2_q <= sum_r[63:0];
        ST_LP3: x1_q <= mres;
        ST_LP4: p4_q <= mres;
        ST_LD6: x1_q <= sum_r[63:0];
        ST_LP5: x2_q <= sum_r[63:0];
        ST_LP6: x3_q <= mres;
        ST_CQ:  qq_q <= alu_res;
        ST_CSQ: tc_q <= (alu_res > NUM_W'(jlpp_pkg::TP_MAX)) ? jlpp_pkg::TP_MAX : res64;
        ST_CM1: p1_q <= mres;
        ST_CM2: p1_q <= mres;
        ST_CM3: p4_q <= mres;
        ST_CD6: p4_q <= $signed(res64);
        ST_CM4: begin
          x1_q <= sum_r[63:0];
          x2_q <= sum_r[63:0];
        end
        ST_CM5: x3_q <= mres;
        default: ;
      endcase
    end
  end

  // clamp fields and gather the result
  always_comb begin
    t2   = tc_q + tm_q;
    t3   = t2 + tc_q;
    c_t1 = clamp_u32(tc_q);
    c_t2 = clamp_u32(t2);
    c_t3 = clamp_u32(t3);
    c_v1 = clamp_s32(v1_q);
    c_v2 = clamp_s32(v2_q);
    c_x1 = clamp_s48(x1_q);
    c_x2 = clamp_s48(x2_q);
    c_x3 = clamp_s48(x3_q);
    res_d.time_first_curve_end = c_t1[31:0];
    res_d.time_linear_end      = c_t2[31:0];
    res_d.time_total           = c_t3[31:0];
    res_d.velocity_after_first = $signed(c_v1[31:0]);
    res_d.velocity_before_last = $signed(c_v2[31:0]);
    res_d.distance_after_first = $signed(c_x1[47:0]);
    res_d.distance_before_last = $signed(c_x2[47:0]);
    res_d.distance_total       = $signed(c_x3[47:0]);
    res_d.has_linear_phase     = lin_q;
    res_d.decelerating         = dec_q;
    res_d.saturated            = sat_q | c_t1[32] | c_t2[32] | c_t3[32] | c_v1[32] |
                                 c_v2[32] | c_x1[48] | c_x2[48] | c_x3[48];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_q == ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_q == ST_OUT && out_free) begin
      out_q <= res_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

endmodule

FILE: hdl/jerk_limited_profile_planner.sv
// ----------------------------------------------------------------------------
// jerk_limited_profile_planner
// Plans a jerk-limited S-curve velocity change for each start/end pair.
// ----------------------------------------------------------------------------
// Each velocity pair is taken by a registered front stage that classifies it
// and parks it in a two-entry queue, so new pairs are accepted while a
// plan is being worked out and while a finished result waits at the output.
// The back end plans one profile at a time on a single shared unit that
// multiplies, divides and takes square roots; that shared unit sets the
// sustained rate. jerk_limit sits at byte address 0, accel_limit at 4; a
// limit of zero acts as one.
module jerk_limited_profile_planner #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jlpp_pkg::ADDR_W-1:0]   paddr,
  input  logic [jlpp_pkg::DATA_W-1:0]   pwdata,
  output logic [jlpp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  jlpp_stream_if.sink                   item_i,
  jlpp_stream_if.source                 result_o
);

  logic [31:0]         jerk_limit_q, accel_limit_q;
  logic                cfg_wr;
  jlpp_pkg::reg_idx_e  reg_idx;

  jlpp_stream_if #(.payload_t(jlpp_pkg::entry_t)) front_ch ();
  jlpp_stream_if #(.payload_t(jlpp_pkg::entry_t)) back_ch ();

  // register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = jlpp_pkg::reg_idx_e'(paddr[jlpp_pkg::ADDR_W-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jerk_limit_q  <= jlpp_pkg::RST_JERK_LIMIT;
      accel_limit_q <= jlpp_pkg::RST_ACCEL_LIMIT;
    end else if (cfg_wr) begin
      case (reg_idx)
        jlpp_pkg::REG_JERK_LIMIT:  jerk_limit_q  <= pwdata;
        jlpp_pkg::REG_ACCEL_LIMIT: accel_limit_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      jlpp_pkg::REG_JERK_LIMIT:  prdata = jerk_limit_q;
      jlpp_pkg::REG_ACCEL_LIMIT: prdata = accel_limit_q;
      default:                   prdata = '0;
    endcase
  end

  jlpp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .jerk_limit_i  (jerk_limit_q),
    .accel_limit_i (accel_limit_q),
    .item_i        (item_i),
    .entry_o       (front_ch.source)
  );

  jlpp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_ch.sink),
    .pop_o  (back_ch.source)
  );

  jlpp_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .entry_i  (back_ch.sink),
    .result_o (result_o)
  );

endmodule

FILE: tb/jlpp_plan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlpp_plan_checker
// Watches the config port and both streams of the profile planner, works out
// the expected plan of every accepted velocity pair and compares each result
// transfer against it in order.
// ----------------------------------------------------------------------------
module jlpp_plan_checker
  import jlpp_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic                pready,
  input  logic                item_valid_i,
  input  logic                item_ready_i,
  input  item_t               item_data_i,
  input  logic                result_valid_i,
  input  logic                result_ready_i,
  input  result_t             result_data_i,
  output int                  pending_o,
  output int                  fail_o
);

  localparam longint LIM = longint'(INNER_LIM);

  logic [31:0] jerk_q;
  logic [31:0] accel_q;
  result_t     plan_q[$];
  int          err_n;

  // fixed point product, magnitude truncated, clamped to the inner bound
  function automatic longint fx_mul(longint a, longint b, inout bit sat);
    logic [127:0] ua, ub, p;
    logic [63:0]  m;
    ua = {64'd0, (a < 0) ? -a : a};
    ub = {64'd0, (b < 0) ? -b : b};
    p  = (ua * ub) >> FRACTION_BITS;
    if (p > {64'd0, INNER_LIM}) begin
      sat = 1'b1;
      m   = INNER_LIM;
    end else begin
      m = p[63:0];
    end
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint fx_add(longint a, longint b, inout bit sat);
    longint r;
    r = a + b;
    if (r > LIM) begin
      sat = 1'b1;
      r   = LIM;
    end
    if (r < -LIM) begin
      sat = 1'b1;
      r   = -LIM;
    end
    return r;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi, inout bit sat);
    if (v < lo) begin
      sat = 1'b1;
      v   = lo;
    end
    if (v > hi) begin
      sat = 1'b1;
      v   = hi;
    end
    return v;
  endfunction

  // floor(sqrt(floor(dv * 2^2F / j)))
  function automatic longint peak_time(longint unsigned dv, longint unsigned j);
    logic [127:0] q, c;
    logic [63:0]  r;
    q = ({64'd0, dv} << (2 * FRACTION_BITS)) / {64'd0, j};
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = {64'd0, r | (64'd1 << i)};
      if (c * c <= q) r = c[63:0];
    end
    return longint'(r);
  endfunction

  function automatic result_t plan_profile(item_t it, logic [31:0] jl, logic [31:0] al);
    result_t         r;
    longint          v0, v3, t1, t2, t3, v1, v2, x1, x2, x3, tc, tm, tp, at, tmp;
    longint unsigned j, a, dv, tcu, tqu;
    longint          dmax;
    bit              dec, lin, sat;
    dmax = (longint'(1) << 47) - 1;
    sat  = 1'b0;
    v0   = longint'(it.start_velocity);
    v3   = longint'(it.end_velocity);
    j    = (jl == 0) ? 64'd1 : {32'd0, jl};
    a    = (al == 0) ? 64'd1 : {32'd0, al};
    dec  = !(v3 > v0);
    dv   = dec ? longint'(v0 - v3) : longint'(v3 - v0);
    lin  = (dv * j) > (a * a);
    if (lin) begin
      tcu = (a << FRACTION_BITS) / j;
      tqu = (dv << FRACTION_BITS) / a;
      tc  = longint'(tcu);
      tm  = (tqu > tcu) ? longint'(tqu - tcu) : 0;
      t1  = tc;
      t2  = tc + tm;
      t3  = t2 + tc;
      at  = fx_mul(longint'(a), tc, sat);
      tmp = at / 2;
      v1  = fx_add(v0, dec ? -tmp : tmp, sat);
      tmp = fx_mul(longint'(a), tm, sat);
      v2  = fx_add(v1, dec ? -tmp : tmp, sat);
      tmp = fx_mul(at, tc, sat) / 6;
      x1  = fx_add(fx_mul(v0, tc, sat), dec ? -tmp : tmp, sat);
      x2  = fx_add(x1, fx_mul(v1, tm, sat), sat);
      x3  = fx_mul((v0 + v3) / 2, t3, sat);
    end else begin
      tp  = peak_time(dv, j);
      tmp = fx_mul(fx_mul(fx_mul(longint'(j), tp, sat), tp, sat), tp, sat) / 6;
      t1  = tp;
      t2  = tp;
      t3  = 2 * tp;
      v1  = (v0 + v3) / 2;
      v2  = v1;
      x1  = fx_add(fx_mul(v1, tp, sat), dec ? -tmp : tmp, sat);
      x2  = x1;
      x3  = fx_mul(2 * v1, tp, sat);
    end
    r.time_first_curve_end = 32'(clip(t1, 0, 64'hFFFF_FFFF, sat));
    r.time_linear_end      = 32'(clip(t2, 0, 64'hFFFF_FFFF, sat));
    r.time_total           = 32'(clip(t3, 0, 64'hFFFF_FFFF, sat));
    r.velocity_after_first = 32'(clip(v1, -64'sd2147483648, 64'sd2147483647, sat));
    r.velocity_before_last = 32'(clip(v2, -64'sd2147483648, 64'sd2147483647, sat));
    r.distance_after_first = 48'(clip(x1, -dmax - 1, dmax, sat));
    r.distance_before_last = 48'(clip(x2, -dmax - 1, dmax, sat));
    r.distance_total       = 48'(clip(x3, -dmax - 1, dmax, sat));
    r.has_linear_phase     = lin;
    r.decelerating         = dec;
    r.saturated            = sat;
    return r;
  endfunction

  task automatic field_check(string f, logic [63:0] e, logic [63:0] g);
    if (e !== g) begin
      err_n++;
      if (err_n <= 10)
        $display("%0t mismatch %s: expected %h, got %h", $realtime, f, e, g);
    end
  endtask

  task automatic result_check(result_t e, result_t g);
    field_check("time_first_curve_end", 64'(e.time_first_curve_end),
                64'(g.time_first_curve_end));
    field_check("time_linear_end", 64'(e.time_linear_end), 64'(g.time_linear_end));
    field_check("time_total", 64'(e.time_total), 64'(g.time_total));
    field_check("velocity_after_first", 64'(e.velocity_after_first),
                64'(g.velocity_after_first));
    field_check("velocity_before_last", 64'(e.velocity_before_last),
                64'(g.velocity_before_last));
    field_check("distance_after_first", 64'(e.distance_after_first),
                64'(g.distance_after_first));
    field_check("distance_before_last", 64'(e.distance_before_last),
                64'(g.distance_before_last));
    field_check("distance_total", 64'(e.distance_total), 64'(g.distance_total));
    field_check("has_linear_phase", 64'(e.has_linear_phase), 64'(g.has_linear_phase));
    field_check("decelerating", 64'(e.decelerating), 64'(g.decelerating));
    field_check("saturated", 64'(e.saturated), 64'(g.saturated));
  endtask

  // follow register writes, queue plans on input transfers, check output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jerk_q  <= RST_JERK_LIMIT;
      accel_q <= RST_ACCEL_LIMIT;
      plan_q.delete();
      err_n   = 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (reg_idx_e'(paddr[2]))
          REG_JERK_LIMIT:  jerk_q  <= pwdata;
          REG_ACCEL_LIMIT: accel_q <= pwdata;
          default: ;
        endcase
      end
      if (result_valid_i && result_ready_i) begin
        if (plan_q.size() == 0) begin
          err_n++;
          if (err_n <= 10) $display("%0t result transfer with no plan waiting", $realtime);
        end else begin
          result_check(plan_q.pop_front(), result_data_i);
        end
      end
      if (item_valid_i && item_ready_i)
        plan_q.push_back(plan_profile(item_data_i, jerk_q, accel_q));
      pending_o <= plan_q.size();
    end
  end

  assign fail_o = err_n;

endmodule

FILE: tb/tb_jerk_limited_profile_planner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jerk_limited_profile_planner
// Drives velocity pairs through the planner under several limit settings,
// with random gaps, output stalls and one long output hold-off; the checker
// beside the block predicts and compares every plan.
// ----------------------------------------------------------------------------
module tb_jerk_limited_profile_planner;
  import jlpp_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int RAND_PER_SET = 165;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                pending_n;
  int                fail_n;
  int                sent_n = 0;
  int                cycle_n = 0;

  jlpp_stream_if #(.payload_t(item_t))   item_ch ();
  jlpp_stream_if #(.payload_t(result_t)) result_ch ();

  jerk_limited_profile_planner u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .item_i   (item_ch),
    .result_o (result_ch)
  );

  jlpp_plan_checker u_plan_check (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .item_valid_i   (item_ch.valid),
    .item_ready_i   (item_ch.ready),
    .item_data_i    (item_ch.data),
    .result_valid_i (result_ch.valid),
    .result_ready_i (result_ch.ready),
    .result_data_i  (result_ch.data),
    .pending_o      (pending_n),
    .fail_o         (fail_n)
  );

  always #10 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n > LIMIT_CYCLES) begin
      $display("[jerk_limited_profile_planner] ERROR");
      $finish;
    end
  end

  // register write: setup then access
  task automatic reg_write(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one input transfer after a random gap, which may be zero
  task automatic send_pair(logic [31:0] v0, logic [31:0] v3);
    int r, gap;
    r = $urandom_range(0, 15);
    gap = (r < 8) ? 0 : (r < 14) ? $urandom_range(1, 4) : $urandom_range(20, 300);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= '{start_velocity: v0, end_velocity: v3};
    do @(posedge clk_i); while (!item_ch.ready);
    sent_n++;
  endtask

  function automatic logic [31:0] pick_velocity();
    case ($urandom_range(0, 4))
      0, 1:    return $urandom();
      2:       return $urandom_range(0, 32'h0064_0000) - 32'h0032_0000;
      3:       return $urandom_range(0, 32'h0000_1000) - 32'h0000_0800;
      default: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                                   : 32'h8000_0000 + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic random_pairs(int n);
    logic [31:0] v0, v3;
    repeat (n) begin
      v0 = pick_velocity();
      // near pairs reach the two-curve case under most limits
      v3 = ($urandom_range(0, 2) == 0) ? v0 + $urandom_range(0, 32'h0004_0000)
                                         - 32'h0002_0000
                                       : pick_velocity();
      send_pair(v0, v3);
    end
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_n != 0) @(posedge clk_i);
  endtask

  // result side: random stalls, one long hold-off once input is flowing
  initial begin
    int n;
    result_ch.ready = 1'b0;
    @(posedge rst_ni);
    while (sent_n < 40) begin
      @(posedge clk_i);
      result_ch.ready <= ($urandom_range(0, 3) != 0);
    end
    @(posedge clk_i);
    result_ch.ready <= 1'b0;
    repeat (3000) @(posedge clk_i);
    forever begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
      if (n > 0) begin
        result_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 60)) @(posedge clk_i);
    end
  end

  // stimulus
  initial begin
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pairs under the reset limits
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'h0005_0000, 32'h0005_0000);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF);
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(32'h0000_0000, 32'h0000_0001);
    send_pair(32'h0000_0001, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'h0000_1999);
    send_pair(32'h0000_0000, 32'h0000_199A);
    send_pair(32'h0000_199B, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'h000A_0000);
    send_pair(32'hFFF6_0000, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'h0000_0001);
    random_pairs(RAND_PER_SET);
    settle();

    // zero limits act as one
    reg_write(REG_JERK_LIMIT, 32'd0);
    reg_write(REG_ACCEL_LIMIT, 32'd0);
    send_pair(32'h0000_0000, 32'h7FFF_FFFF);
    send_pair(32'h0000_0000, 32'h0000_0001);
    random_pairs(RAND_PER_SET);
    settle();

    // largest limits
    reg_write(REG_JERK_LIMIT, 32'hFFFF_FFFF);
    reg_write(REG_ACCEL_LIMIT, 32'hFFFF_FFFF);
    random_pairs(RAND_PER_SET);
    settle();

    // small jerk, large acceleration
    reg_write(REG_JERK_LIMIT, 32'd1);
    random_pairs(RAND_PER_SET);
    settle();

    // large jerk, small acceleration
    reg_write(REG_JERK_LIMIT, 32'hFFFF_FFFF);
    reg_write(REG_ACCEL_LIMIT, 32'd1);
    random_pairs(RAND_PER_SET);
    settle();

    // realistic random limits, then fully random ones
    repeat (2) begin
      reg_write(REG_JERK_LIMIT, $urandom_range(32'h0001_0000, 32'h0064_0000));
      reg_write(REG_ACCEL_LIMIT, $urandom_range(32'h0000_4000, 32'h0014_0000));
      random_pairs(RAND_PER_SET / 2);
      settle();
    end

    reg_write(REG_JERK_LIMIT, $urandom());
    reg_write(REG_ACCEL_LIMIT, $urandom());
    random_pairs(RAND_PER_SET);
    settle();

    repeat (200) @(posedge clk_i);
    if (fail_n == 0 && pending_n == 0) begin
      $display("[jerk_limited_profile_planner] OK");
    end else begin
      $display("[jerk_limited_profile_planner] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/jlpp_pkg.sv
hdl/jlpp_stream_if.sv
hdl/jlpp_front.sv
hdl/jlpp_queue.sv
hdl/jlpp_alu.sv
hdl/jlpp_back.sv
hdl/jerk_limited_profile_planner.sv
tb/jlpp_plan_checker.sv
tb/tb_jerk_limited_profile_planner.sv
